/* src/sroc_pkg.sv */
// Shared types and constants for the sorted record order checker.
// No dependencies; every other source file except sroc_ram imports this package.
package sroc_pkg;

    localparam int MAX_RECORD_WORDS_DEF = 256;
    localparam int INDEX_WIDTH_DEF      = 32;
    localparam int DATA_W               = 64;
    localparam int IDX_OUT_W            = 32;

    // Front-to-back queue; depth must be a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int LEVEL_W     = $clog2(QUEUE_DEPTH + 1);

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_ORDER    = 2'd1;
    localparam logic [1:0] ST_OVERSIZE = 2'd2;
    localparam logic [1:0] ST_TRUNC    = 2'd3;

    typedef struct packed {
        logic [DATA_W-1:0] data_word;
        logic              last_word;
    } in_item_t;

    typedef struct packed {
        logic [1:0]           status;
        logic [IDX_OUT_W-1:0] record_index;
        logic                 all_in_order;
    } out_item_t;

    // What the back end must do with a queued word
    typedef enum logic [1:0] {
        K_TAKE  = 2'd0,   // payload word, record still open
        K_CLOSE = 2'd1,   // payload word that completes the record
        K_OVER  = 2'd2,   // header calls for too many words
        K_TRUNC = 2'd3    // stream ended inside the record
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic              first;        // header word, restarts the compare
        logic              have_prev;
        logic              in_range;     // position lies within previous payload
        logic              prev_longer;  // previous payload longer than this one
        logic [DATA_W-1:0] word;
    } q_entry_t;

    typedef struct packed {
        q_entry_t          ent;
        logic [DATA_W-1:0] prev_word;
    } q_item_t;

endpackage

/* src/sroc_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module sroc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/sroc_front.sv */
// Front end: deframes records, decodes header length, drives the store ports
// and hands one classified entry per payload word to the queue. Uses sroc_pkg.
module sroc_front import sroc_pkg::*; #(
    parameter int MAX_RECORD_WORDS = MAX_RECORD_WORDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  in_item_t                            in_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [1:0]                          cfg_data,
    input  logic [LEVEL_W-1:0]                  q_level,
    output logic                                s1_valid,
    output q_entry_t                            s1_entry,
    output logic                                wr_en,
    output logic [$clog2(MAX_RECORD_WORDS):0]   wr_addr,
    output logic [DATA_W-1:0]                   wr_data,
    output logic [$clog2(MAX_RECORD_WORDS):0]   rd_addr
);

    localparam int POS_W = $clog2(MAX_RECORD_WORDS);
    localparam int CNT_W = $clog2(MAX_RECORD_WORDS + 1);
    localparam int SUM_W = LEVEL_W + 1;

    typedef enum logic [1:0] {
        PH_KEY    = 2'd0,
        PH_HEADER = 2'd1,
        PH_BODY   = 2'd2
    } phase_t;

    phase_t           phase_reg, phase_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] expected_reg, expected_next;
    logic [CNT_W-1:0] prev_words_reg, prev_words_next;
    logic             bank_reg, bank_next;
    logic             have_prev_reg, have_prev_next;
    logic             halted_reg, halted_next;
    logic [1:0]       color_code_reg;
    logic             s1_valid_reg;
    q_entry_t         s1_entry_reg;

    logic             accept;
    logic             work;
    logic [SUM_W-1:0] level_sum;
    logic [DATA_W-1:0] quot;
    logic             oversize;
    logic             oversize_hit;
    logic [CNT_W-1:0] exp_hdr;
    logic [CNT_W-1:0] cur_pos;
    logic [CNT_W-1:0] cur_exp;
    logic [CNT_W-1:0] pos_inc;
    logic             closes;
    q_entry_t         entry;

    // Space is reserved for the entry already in flight to the queue
    assign level_sum = SUM_W'(q_level) + SUM_W'(s1_valid_reg);
    assign in_stall  = level_sum >= SUM_W'(QUEUE_DEPTH);
    assign accept    = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    // List size divided by words-per-colour folds into one fixed shift per code
    always_comb
    begin
        unique case (color_code_reg)
            2'd0:    quot = in_data.data_word >> 59;
            2'd1:    quot = in_data.data_word >> 50;
            2'd2:    quot = in_data.data_word >> 33;
            default: quot = in_data.data_word;
        endcase
    end

    assign oversize     = quot >= DATA_W'(MAX_RECORD_WORDS);
    assign exp_hdr      = CNT_W'(quot) + CNT_W'(1);
    assign oversize_hit = (phase_reg == PH_HEADER) && oversize;
    assign cur_pos      = (phase_reg == PH_HEADER) ? '0 : pos_reg;
    assign cur_exp      = (phase_reg == PH_HEADER) ? exp_hdr : expected_reg;
    assign pos_inc      = cur_pos + CNT_W'(1);
    assign closes       = pos_inc >= cur_exp;
    assign work         = accept && !halted_reg && (phase_reg != PH_KEY);

    always_comb
    begin
        entry.first       = (phase_reg == PH_HEADER);
        entry.have_prev   = have_prev_reg;
        entry.in_range    = cur_pos < prev_words_reg;
        entry.prev_longer = prev_words_reg > cur_exp;
        entry.word        = in_data.data_word;
        if (oversize_hit)
            entry.kind = K_OVER;
        else if (closes)
            entry.kind = K_CLOSE;
        else if (in_data.last_word)
            entry.kind = K_TRUNC;
        else
            entry.kind = K_TAKE;
    end

    assign wr_en   = work && !oversize_hit;
    assign wr_addr = {bank_reg, cur_pos[POS_W-1:0]};
    assign wr_data = in_data.data_word;
    assign rd_addr = {~bank_reg, cur_pos[POS_W-1:0]};

    always_comb
    begin
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        expected_next   = expected_reg;
        prev_words_next = prev_words_reg;
        bank_next       = bank_reg;
        have_prev_next  = have_prev_reg;
        halted_next     = halted_reg;
        if (accept && !halted_reg)
        begin
            unique case (phase_reg) inside
                PH_KEY:
                begin
                    phase_next = in_data.last_word ? PH_KEY : PH_HEADER;
                end
                PH_HEADER, PH_BODY:
                begin
                    if (oversize_hit)
                    begin
                        halted_next = 1'b1;
                    end
                    else if (closes)
                    begin
                        prev_words_next = cur_exp;
                        bank_next       = ~bank_reg;
                        have_prev_next  = 1'b1;
                        phase_next      = PH_KEY;
                        pos_next        = '0;
                    end
                    else if (in_data.last_word)
                    begin
                        halted_next = 1'b1;
                    end
                    else
                    begin
                        phase_next    = PH_BODY;
                        pos_next      = pos_inc;
                        expected_next = cur_exp;
                    end
                end
                default:
                begin
                    phase_next = PH_KEY;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_KEY;
            pos_reg        <= '0;
            expected_reg   <= '0;
            prev_words_reg <= '0;
            bank_reg       <= 1'b0;
            have_prev_reg  <= 1'b0;
            halted_reg     <= 1'b0;
            color_code_reg <= 2'd0;
            s1_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            expected_reg   <= expected_next;
            prev_words_reg <= prev_words_next;
            bank_reg       <= bank_next;
            have_prev_reg  <= have_prev_next;
            halted_reg     <= halted_next;
            s1_valid_reg   <= work;
            if (cfg_valid && cfg_ready)
            begin
                color_code_reg <= cfg_data;
            end
        end
    end

    // Entry is registered so it meets the registered store read
    always_ff @(posedge clk)
    begin
        s1_entry_reg <= entry;
    end

    assign s1_valid = s1_valid_reg;
    assign s1_entry = s1_entry_reg;

    a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |=> !s1_valid_reg)
        else $error("front issued an entry while halted");

endmodule

/* src/sroc_queue.sv */
// Short FIFO between front and back ends, entries held in flops.
// Uses sroc_pkg for the entry type and depth.
module sroc_queue import sroc_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  q_item_t            push_item,
    input  logic               pop,
    output logic               head_valid,
    output q_item_t            head,
    output logic [LEVEL_W-1:0] level
);

    q_item_t             slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [LEVEL_W-1:0]  count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + LEVEL_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - LEVEL_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign head_valid = count_reg != '0;
    assign head       = slot_reg[rd_ptr_reg];
    assign level      = count_reg;

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push && !pop |-> count_reg < LEVEL_W'(QUEUE_DEPTH))
        else $error("queue overflow");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != '0)
        else $error("queue underflow");

endmodule

/* src/sroc_back.sv */
// Back end: running lexicographic compare, status decision, record counter,
// sticky flag and the output register. Uses sroc_pkg.
module sroc_back import sroc_pkg::*; #(
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  q_item_t   head,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    typedef enum logic [1:0] {
        CMP_EQUAL   = 2'd0,
        CMP_LESS    = 2'd1,
        CMP_GREATER = 2'd2
    } cmp_t;

    cmp_t                   cmp_reg;
    logic [INDEX_WIDTH-1:0] counter_reg;
    logic                   sticky_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    cmp_t       cmp_base;
    cmp_t       cmp_new;
    logic       produces;
    logic       order_bad;
    logic [1:0] status_new;
    logic       sticky_new;

    assign produces = head.ent.kind != K_TAKE;
    assign pop      = head_valid && (!produces || !out_valid_reg || !out_stall);

    // The first differing word decides; a shorter previous payload is the lesser
    always_comb
    begin
        cmp_base = head.ent.first ? CMP_EQUAL : cmp_reg;
        cmp_new  = cmp_base;
        if (head.ent.have_prev && (cmp_base == CMP_EQUAL))
        begin
            if (!head.ent.in_range)
                cmp_new = CMP_LESS;
            else if (head.prev_word > head.ent.word)
                cmp_new = CMP_GREATER;
            else if (head.prev_word < head.ent.word)
                cmp_new = CMP_LESS;
        end
    end

    assign order_bad = head.ent.have_prev &&
                       ((cmp_new == CMP_GREATER) ||
                        ((cmp_new == CMP_EQUAL) && head.ent.prev_longer));

    always_comb
    begin
        unique case (head.ent.kind)
            K_TAKE:  status_new = ST_OK;
            K_CLOSE: status_new = order_bad ? ST_ORDER : ST_OK;
            K_OVER:  status_new = ST_OVERSIZE;
            K_TRUNC: status_new = ST_TRUNC;
            default: status_new = ST_OK;
        endcase
    end

    assign sticky_new = sticky_reg && (status_new == ST_OK);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmp_reg       <= CMP_EQUAL;
            counter_reg   <= '0;
            sticky_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop && produces)
            begin
                out_valid_reg <= 1'b1;
                sticky_reg    <= sticky_new;
                cmp_reg       <= CMP_EQUAL;
                if (head.ent.kind == K_CLOSE)
                begin
                    counter_reg <= counter_reg + INDEX_WIDTH'(1);
                end
            end
            else
            begin
                if (!out_stall)
                begin
                    out_valid_reg <= 1'b0;
                end
                if (pop)
                begin
                    cmp_reg <= cmp_new;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && produces)
        begin
            out_reg.status       <= status_new;
            out_reg.record_index <= IDX_OUT_W'(counter_reg);
            out_reg.all_in_order <= sticky_new;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_sticky_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !sticky_reg |=> !sticky_reg)
        else $error("sticky flag set again after a failure");

    a_fail_clears_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status != ST_OK) |-> !out_reg.all_in_order)
        else $error("failure reported with flag still set");

endmodule

/* src/sorted_record_order_checker_top.sv */
// Sorted record order checker top level: front end, queue, back end, store.
// Uses sroc_pkg, sroc_front, sroc_queue, sroc_back and sroc_ram.
//
// Takes one 64-bit stream word per cycle without pause while the result side
// keeps up. Each request is one word; records are key, header, then payload.
// A record's result passes the in-flight register, the queue and the output
// register once its closing word is taken, held up only while out_stall holds
// earlier results back. The payload store is a two-bank RAM, each bank of
// MAX_RECORD_WORDS words rounded to a power of two, with one write and one
// registered read per cycle; an entry meets its read before the 4-deep queue.
// The queue lets the input run on while a finished result waits on out_stall;
// input stalls once the queue and the in-flight entry fill it. The colour
// width register may be written only while the block is idle. After an
// oversize or truncated record the block drops all words until reset.
module sorted_record_order_checker_top import sroc_pkg::*; #(
    parameter int MAX_RECORD_WORDS = MAX_RECORD_WORDS_DEF,
    parameter int INDEX_WIDTH      = INDEX_WIDTH_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data,
    input  logic      cfg_valid,
    output logic      cfg_ready,
    input  logic [1:0] cfg_data
);

    localparam int ADDR_W    = $clog2(MAX_RECORD_WORDS) + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;

    logic               s1_valid;
    q_entry_t           s1_entry;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [DATA_W-1:0]  wr_data;
    logic [ADDR_W-1:0]  rd_addr;
    logic [DATA_W-1:0]  rd_data;
    q_item_t            push_item;
    logic               head_valid;
    q_item_t            head;
    logic               pop;
    logic [LEVEL_W-1:0] q_level;

    sroc_front #(
        .MAX_RECORD_WORDS(MAX_RECORD_WORDS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data),
        .q_level  (q_level),
        .s1_valid (s1_valid),
        .s1_entry (s1_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_data  (wr_data),
        .rd_addr  (rd_addr)
    );

    sroc_ram #(
        .WIDTH(DATA_W),
        .DEPTH(RAM_DEPTH)
    ) u_store (
        .clk    (clk),
        .wr_en  (wr_en),
        .wr_addr(wr_addr),
        .wr_data(wr_data),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb
    begin
        push_item.ent       = s1_entry;
        push_item.prev_word = rd_data;
    end

    sroc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s1_valid),
        .push_item (push_item),
        .pop       (pop),
        .head_valid(head_valid),
        .head      (head),
        .level     (q_level)
    );

    sroc_back #(
        .INDEX_WIDTH(INDEX_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_valid(head_valid),
        .head      (head),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

/* sim/sorted_record_order_checker_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for sorted_record_order_checker_top: streams framed records,
// predicts each verdict in a scoreboard class and checks it. Needs sroc_pkg.
module sorted_record_order_checker_top_tb;
    import sroc_pkg::*;

    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 300;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int SEG_WORDS     = 125;

    typedef enum logic [1:0] {FR_KEY, FR_HEADER, FR_BODY} frame_t;
    typedef enum logic [1:0] {ORD_EQUAL, ORD_LESS, ORD_GREATER} order_t;

    class verdict_scoreboard;
        logic [63:0] payload_store [2*MAX_RECORD_WORDS_DEF];
        bit          bank;
        frame_t      phase;
        order_t      order;
        int unsigned pos;
        int unsigned need;
        int unsigned prev_len;
        bit          have_prev;
        bit          sticky_ok;
        bit          halted;
        logic [31:0] rec_count;
        logic [1:0]  width_code;
        out_item_t   pending_verdicts [$];
        int unsigned mismatches;

        function new();
            bank       = 1'b0;
            phase      = FR_KEY;
            order      = ORD_EQUAL;
            pos        = 0;
            need       = 0;
            prev_len   = 0;
            have_prev  = 1'b0;
            sticky_ok  = 1'b1;
            halted     = 1'b0;
            rec_count  = '0;
            width_code = 2'd0;
            mismatches = 0;
        endfunction

        function void set_width_code(logic [1:0] code);
            width_code = code;
        endfunction

        function int unsigned outstanding();
            return pending_verdicts.size();
        endfunction

        function void push_verdict(logic [1:0] st);
            out_item_t v;
            v.status       = st;
            v.record_index = rec_count;
            v.all_in_order = sticky_ok;
            pending_verdicts = {pending_verdicts, v};
        endfunction

        function void halt(logic [1:0] st);
            sticky_ok = 1'b0;
            halted    = 1'b1;
            push_verdict(st);
        endfunction

        // compare against the previous payload until a word decides, then store
        function void store_word(logic [63:0] w);
            logic [63:0] prev;
            if (have_prev && order == ORD_EQUAL)
            begin
                if (pos >= prev_len)
                    order = ORD_LESS;
                else
                begin
                    prev = payload_store[(bank ? 0 : MAX_RECORD_WORDS_DEF) + pos];
                    if (prev > w)
                        order = ORD_GREATER;
                    else if (prev < w)
                        order = ORD_LESS;
                end
            end
            payload_store[(bank ? MAX_RECORD_WORDS_DEF : 0) + pos] = w;
            pos++;
        endfunction

        function void accept_word(in_item_t it);
            int unsigned w;
            logic [63:0] quot;
            logic [1:0]  st;
            if (halted)
                return;
            if (phase == FR_KEY)
            begin
                if (!it.last_word)
                    phase = FR_HEADER;
                return;
            end
            if (phase == FR_HEADER)
            begin
                w    = 8 << width_code;
                quot = (it.data_word >> (64 - w)) >> (3 - width_code);
                if (quot >= MAX_RECORD_WORDS_DEF)
                begin
                    halt(ST_OVERSIZE);   // oversize beats last_word
                    return;
                end
                need  = int'(quot) + 1;
                pos   = 0;
                order = ORD_EQUAL;
                phase = FR_BODY;
            end
            store_word(it.data_word);
            if (pos >= need)
            begin
                st = ST_OK;
                if (have_prev && (order == ORD_GREATER ||
                                  (order == ORD_EQUAL && prev_len > need)))
                    st = ST_ORDER;
                if (st != ST_OK)
                    sticky_ok = 1'b0;
                push_verdict(st);
                prev_len  = need;
                bank      = ~bank;
                have_prev = 1'b1;
                rec_count = rec_count + 32'd1;
                phase     = FR_KEY;
                pos       = 0;
                order     = ORD_EQUAL;
            end
            else if (it.last_word)
                halt(ST_TRUNC);
        endfunction

        function void report(string what, logic [31:0] want, logic [31:0] got);
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, what, want, got);
        endfunction

        function void check_verdict(out_item_t got);
            out_item_t want;
            if (pending_verdicts.size() == 0)
            begin
                mismatches++;
                $display("%0t: expected no result, got status %0d index %0h flag %0b",
                         $time, got.status, got.record_index, got.all_in_order);
                return;
            end
            want = pending_verdicts.pop_front();
            if (got.status !== want.status)
                report("status", 32'(want.status), 32'(got.status));
            if (got.record_index !== want.record_index)
                report("record_index", want.record_index, got.record_index);
            if (got.all_in_order !== want.all_in_order)
                report("all_in_order", 32'(want.all_in_order), 32'(got.all_in_order));
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;

    verdict_scoreboard sb = new();

    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    bit          hold_req;
    int unsigned words_sent;
    int unsigned cycles;
    logic [1:0]  colour_code;
    logic [63:0] next_payload [$];
    logic [63:0] prev_payload [$];

    sorted_record_order_checker_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("sorted_record_order_checker_top_tb NOT OK");
        $finish;
    end

    // result side: random stall, plus one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_verdict(out_data);
    end

    function automatic logic [63:0] rand_word();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 8)
            return '0;
        if (r < 16)
            return '1;
        return {$urandom, $urandom};
    endfunction

    // header whose length field gives q+1 payload words at this colour width
    function automatic logic [63:0] make_header(int unsigned q, logic [1:0] code);
        int unsigned w;
        logic [63:0] len;
        logic [63:0] rest;
        w    = 8 << code;
        len  = (64'(q) << (3 - code)) | 64'($urandom_range(0, (1 << (3 - code)) - 1));
        rest = {$urandom, $urandom};
        if (w == 64)
            return len;
        return (len << (64 - w)) | (rest & ((64'd1 << (64 - w)) - 64'd1));
    endfunction

    function automatic logic [63:0] header_quot(logic [63:0] hdr, logic [1:0] code);
        int unsigned w;
        w = 8 << code;
        return (hdr >> (64 - w)) >> (3 - code);
    endfunction

    task automatic send_word(logic [63:0] w, logic last);
        in_item_t it;
        it.data_word = w;
        it.last_word = last;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sb.accept_word(it);
        words_sent++;
    endtask

    task automatic send_record(logic [63:0] key, bit end_stream);
        int i;
        send_word(key, 1'b0);
        for (i = 0; i < next_payload.size(); i++)
            send_word(next_payload[i], end_stream && (i == next_payload.size() - 1));
        prev_payload = next_payload;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_width_code(logic [1:0] code);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.set_width_code(code);
        colour_code = code;
        cfg_valid <= 1'b0;
    endtask

    // Half the time near-copies of the previous payload so that compares go deep;
    // after a width change the same header gives another length (prefix cases).
    task automatic build_record();
        int unsigned r;
        int unsigned q;
        int unsigned k;
        int          i;
        logic [63:0] hq;
        r = $urandom_range(0, 99);
        next_payload.delete();
        hq = (prev_payload.size() != 0) ? header_quot(prev_payload[0], colour_code)
                                        : 64'hFFFF;
        if (r < 50 && hq < MAX_RECORD_WORDS_DEF)
        begin
            next_payload = {next_payload, prev_payload[0]};
            for (i = 1; i <= hq; i++)
                next_payload = {next_payload, (i < prev_payload.size() ? prev_payload[i]
                                                                      : rand_word())};
            if (r >= 15 && hq != 0)
            begin
                k = $urandom_range(1, int'(hq));
                case ($urandom_range(0, 2))
                    0: next_payload[k] = next_payload[k] + 64'd1;
                    1: next_payload[k] = next_payload[k] - 64'd1;
                    default: next_payload[k] = rand_word();
                endcase
            end
        end
        else
        begin
            r = $urandom_range(0, 99);
            if (r < 3)
                q = (colour_code == 2'd0) ? 31 : MAX_RECORD_WORDS_DEF - 1;
            else if (r < 75)
                q = $urandom_range(0, 3);
            else
                q = $urandom_range(0, 31);
            next_payload = {next_payload, make_header(q, colour_code)};
            repeat (q) next_payload = {next_payload, rand_word()};
        end
    endtask

    initial
    begin
        int          seg;
        int unsigned r;
        int unsigned target;
        logic [1:0]  code_seq [8];
        logic [63:0] short_hdr;

        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_data       = 2'd0;
        send_idle_pct  = 25;
        recv_stall_pct = 79;
        hold_req       = 1'b0;
        words_sent     = 0;
        colour_code    = 2'd0;
        code_seq       = '{2'd0, 2'd3, 2'd1, 2'd2, 2'd3, 2'd0, 2'd2, 2'd1};
        // one word at 8-bit colour, three words at 32-bit colour
        short_hdr      = 64'h0000_0004_0000_0000;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_width_code(2'd0);
        next_payload = '{64'h0};
        send_record(64'h0, 1'b0);
        next_payload = '{64'h0};                      // equal payloads
        send_record('1, 1'b0);
        next_payload = '{64'h0800_0000_0000_0000, '1};
        send_record(rand_word(), 1'b0);
        next_payload = '{64'h0};                      // lower than before
        send_record(rand_word(), 1'b0);
        send_word(rand_word(), 1'b1);                 // key alone ends the stream
        next_payload = '{short_hdr};
        send_record(rand_word(), 1'b1);
        drain_results();
        write_width_code(2'd2);
        next_payload = '{short_hdr, '1, 64'h0};       // previous is a prefix
        send_record(rand_word(), 1'b0);
        drain_results();
        write_width_code(2'd0);
        next_payload = '{short_hdr};                  // prefix of the previous
        send_record(rand_word(), 1'b0);

        for (seg = 0; seg < 8; seg++)
        begin
            if (seg == 3)
            begin
                send_idle_pct  = 79;
                recv_stall_pct = 25;
            end
            if (seg == 6)
            begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            drain_results();
            write_width_code(code_seq[seg]);
            if (seg == 6)
                hold_req = 1'b1;
            target = words_sent + SEG_WORDS;
            while (words_sent < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    send_word(rand_word(), 1'b1);
                else
                begin
                    build_record();
                    send_record(rand_word(), r < 12);
                end
            end
        end

        // one fatal record at the end, then words the halted block must drop
        drain_results();
        write_width_code(2'($urandom_range(1, 3)));
        send_word(rand_word(), 1'b0);
        case ($urandom_range(0, 3))
            0: send_word(rand_word() | 64'h8000_0000_0000_0000, 1'b0);
            1: send_word(rand_word() | 64'h8000_0000_0000_0000, 1'b1);
            2: send_word(make_header($urandom_range(1, 3), colour_code), 1'b1);
            default:
            begin
                send_word(make_header($urandom_range(2, 3), colour_code), 1'b0);
                send_word(rand_word(), 1'b1);
            end
        endcase
        repeat (6) send_word(rand_word(), 1'($urandom_range(0, 1)));
        drain_results();

        if (sb.mismatches == 0)
            $display("sorted_record_order_checker_top_tb OK");
        else
            $display("sorted_record_order_checker_top_tb NOT OK");
        $finish;
    end

endmodule
